// ----- rtl/bmmd_pkg.sv -----
package bmmd_pkg;

  // bus commands
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // where an access is served
  typedef enum logic [1:0] {
    TGT_INTERNAL = 2'd0,
    TGT_VIDEO    = 2'd1,
    TGT_IO       = 2'd2
  } tgt_e;

  // source of the read byte
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_DIR,
    SRC_PORT,
    SRC_RAM,
    SRC_BASIC,
    SRC_KERNAL
  } src_e;

  // clear sequencer states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } clr_state_e;

  // decoded access
  typedef struct packed {
    src_e src;
    tgt_e tgt;
    logic dir_we;
    logic data_we;
    logic ram_we;
    logic basic_we;
    logic kernal_we;
  } dec_t;

  // map constants
  localparam logic [15:0] AddrDir     = 16'h0000;
  localparam logic [15:0] AddrData    = 16'h0001;
  localparam logic [7:0]  PagePort    = 8'h00;
  localparam logic [7:0]  PageIo      = 8'hFD;
  localparam logic [7:0]  PageVideo   = 8'hFF;
  localparam logic [15:0] IoLow       = 16'hFD30;
  localparam logic [15:0] IoHigh      = 16'hFD3F;
  localparam logic [15:0] VideoEnd    = 16'hFF20;
  localparam logic [15:0] VideoWrLo   = 16'hFF3E;
  localparam logic [15:0] VideoWrHi   = 16'hFF3F;
  localparam logic [1:0]  RomBasic    = 2'b10;
  localparam logic [1:0]  RomKernal   = 2'b11;
  localparam logic [7:0]  PortMask    = 8'h3F;
  localparam int unsigned ClearRunBit = 6;

endpackage

// ----- rtl/bmmd_ram.sv -----
module bmmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/bmmd_decode.sv -----
module bmmd_decode (
  input  logic [1:0]      command_i,
  input  logic [15:0]     address_i,
  input  logic            memory_mode_i,
  output bmmd_pkg::dec_t  dec_o
);
  import bmmd_pkg::*;

  logic [7:0] page;
  logic       in_io;
  logic       video_rd;
  logic       video_wr;

  assign page     = address_i[15:8];
  assign in_io    = (address_i >= IoLow) && (address_i <= IoHigh);
  assign video_rd = (page == PageVideo) && (address_i < VideoEnd);
  assign video_wr = video_rd || (address_i == VideoWrLo) || (address_i == VideoWrHi);

  // map the access onto its source, target and write strobes
  always_comb begin
    dec_o = '{src: SRC_ZERO, tgt: TGT_INTERNAL, default: 1'b0};
    case (cmd_e'(command_i))
      CMD_READ: begin
        if (page == PagePort) begin
          if (address_i == AddrDir) begin
            dec_o.src = SRC_DIR;
          end else if (address_i == AddrData) begin
            dec_o.src = SRC_PORT;
          end else begin
            dec_o.src = SRC_RAM;
          end
        end else if (page == PageIo) begin
          if (in_io) begin
            dec_o.tgt = TGT_IO;
          end
        end else if (video_rd) begin
          dec_o.tgt = TGT_VIDEO;
        end else if (memory_mode_i && address_i[15]) begin
          dec_o.src = (address_i[15:14] == RomKernal) ? SRC_KERNAL : SRC_BASIC;
        end else begin
          dec_o.src = SRC_RAM;
        end
      end
      CMD_WRITE: begin
        if (address_i == AddrDir) begin
          dec_o.dir_we = 1'b1;
        end else if (address_i == AddrData) begin
          dec_o.data_we = 1'b1;
        end else if (page == PageIo) begin
          if (in_io) begin
            dec_o.tgt = TGT_IO;
          end
        end else if ((page == PageVideo) && video_wr) begin
          dec_o.tgt = TGT_VIDEO;
        end else begin
          dec_o.ram_we = 1'b1;
        end
      end
      CMD_LOAD: begin
        dec_o.kernal_we = (address_i[15:14] == RomKernal);
        dec_o.basic_we  = (address_i[15:14] == RomBasic);
      end
      default: begin
        dec_o.src = SRC_ZERO;
      end
    endcase
  end

endmodule

// ----- rtl/banked_memory_map_decoder.sv -----
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_stall_o   command, address, write_data, serial_bits
// out      output     out_valid_o / out_stall_i read_data, device_target, port_written,
//                                               port_output
// cfg      input      cfg_we_i                  cfg_wdata_i (memory_mode)
//
// one item per cycle while the input is not stalled; a result passes from the read stage,
// which holds the registered read of the RAM and ROM memories, into the output register.
// after reset a clearing pass writes the run pattern into all RAM_WORDS RAM entries
// (65536 by default); no input transfer is taken until it ends.
// a stalled result holds in the output register while the next item waits in the read
// stage; input stalls in the clearing pass or when both hold items and the result stalls.
module banked_memory_map_decoder #(
  parameter int unsigned RAM_WORDS = 65536,
  parameter int unsigned ROM_WORDS = 16384
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic [15:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] serial_bits_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [1:0] device_target_o,
  output logic       port_written_o,
  output logic [7:0] port_output_o
);
  import bmmd_pkg::*;

  localparam int unsigned RamAw = $clog2(RAM_WORDS);
  localparam int unsigned RomAw = $clog2(ROM_WORDS);

  dec_t       dec;
  logic       accept;
  logic       move;
  logic       mode_q;
  logic [7:0] dir_q, dir_d;
  logic [7:0] data_q, data_d;
  logic       pw;
  logic [7:0] imm;

  clr_state_e           state_q, state_d;
  logic [RamAw-1:0]     clr_addr_q, clr_addr_d;
  logic                 clr_busy;

  logic                 pend_valid_q, pend_valid_d;
  src_e                 pend_src_q;
  logic [7:0]           pend_imm_q;
  tgt_e                 pend_tgt_q;
  logic                 pend_pw_q;
  logic [7:0]           pend_po_q;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_rd_q, out_rd_d;
  tgt_e                 out_tgt_q;
  logic                 out_pw_q;
  logic [7:0]           out_po_q;

  logic                 ram_we;
  logic [RamAw-1:0]     ram_waddr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_rdata;
  logic [7:0]           basic_rdata;
  logic [7:0]           kernal_rdata;

  // address decode
  bmmd_decode u_decode (
    .command_i     (command_i),
    .address_i     (address_i),
    .memory_mode_i (mode_q),
    .dec_o         (dec)
  );

  // clear sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_addr_q <= '0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // clear sequencer next state
  always_comb begin
    state_d    = state_q;
    clr_addr_d = clr_addr_q;
    clr_busy   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_busy   = 1'b1;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == {RamAw{1'b1}}) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_busy = 1'b0;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // handshake
  assign move       = pend_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy || (pend_valid_q && !move);
  assign accept     = in_valid_i && !in_stall_o;

  // memory mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // processor port update
  always_comb begin
    dir_d  = dir_q;
    data_d = data_q;
    pw     = 1'b0;
    if (accept && dec.dir_we) begin
      dir_d = write_data_i;
      pw    = (dir_q != write_data_i);
    end
    if (accept && dec.data_we) begin
      data_d = write_data_i;
      pw     = (data_q != write_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= '0;
      data_q <= '0;
    end else begin
      dir_q  <= dir_d;
      data_q <= data_d;
    end
  end

  // port and constant read bytes
  always_comb begin
    case (dec.src)
      SRC_DIR:  imm = dir_q;
      SRC_PORT: imm = ((data_q | ~dir_q) & PortMask) | serial_bits_i;
      default:  imm = '0;
    endcase
  end

  // RAM write port shared by clearing pass and CPU writes
  assign ram_we    = clr_busy || (accept && dec.ram_we);
  assign ram_waddr = clr_busy ? clr_addr_q : address_i[RamAw-1:0];
  assign ram_wdata = clr_busy ? {8{clr_addr_q[ClearRunBit]}} : write_data_i;

  bmmd_ram #(
    .WIDTH (8),
    .DEPTH (RAM_WORDS)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (address_i[RamAw-1:0]),
    .rdata_o (ram_rdata)
  );

  bmmd_ram #(
    .WIDTH (8),
    .DEPTH (ROM_WORDS)
  ) u_basic_rom (
    .clk_i   (clk_i),
    .we_i    (accept && dec.basic_we),
    .waddr_i (address_i[RomAw-1:0]),
    .wdata_i (write_data_i),
    .re_i    (accept),
    .raddr_i (address_i[RomAw-1:0]),
    .rdata_o (basic_rdata)
  );

  bmmd_ram #(
    .WIDTH (8),
    .DEPTH (ROM_WORDS)
  ) u_kernal_rom (
    .clk_i   (clk_i),
    .we_i    (accept && dec.kernal_we),
    .waddr_i (address_i[RomAw-1:0]),
    .wdata_i (write_data_i),
    .re_i    (accept),
    .raddr_i (address_i[RomAw-1:0]),
    .rdata_o (kernal_rdata)
  );

  // read stage: item waiting on memory data
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (accept) begin
      pend_valid_d = 1'b1;
    end else if (move) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_src_q <= dec.src;
      pend_imm_q <= imm;
      pend_tgt_q <= dec.tgt;
      pend_pw_q  <= pw;
      pend_po_q  <= ~(data_d | ~dir_d);
    end
  end

  // output register
  always_comb begin
    case (pend_src_q)
      SRC_RAM:    out_rd_d = ram_rdata;
      SRC_BASIC:  out_rd_d = basic_rdata;
      SRC_KERNAL: out_rd_d = kernal_rdata;
      default:    out_rd_d = pend_imm_q;
    endcase
    out_valid_d = move || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_rd_q  <= out_rd_d;
      out_tgt_q <= pend_tgt_q;
      out_pw_q  <= pend_pw_q;
      out_po_q  <= pend_po_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rd_q;
  assign device_target_o = out_tgt_q;
  assign port_written_o  = out_pw_q;
  assign port_output_o   = out_po_q;

`ifndef SYNTHESIS
  // no transfer while the RAM is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("input taken during RAM clearing pass");

  // clearing pass ends after the last RAM entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && (clr_addr_q == {RamAw{1'b1}})) |=> (state_q == ST_RUN))
    else $error("clearing pass did not finish");

  // a port change is an internal write and reads zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && port_written_o) |->
      ((device_target_o == TGT_INTERNAL) && (read_data_o == 8'h00)))
    else $error("port write result carries read data or a target");

  // a ROM load never touches RAM
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_LOAD)) |-> !ram_we)
    else $error("ROM load wrote RAM");
`endif

endmodule
